// ===== rtl/wpsp_pkg.sv =====
package wpsp_pkg;

  // One input request: a file byte and its end-of-file mark.
  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } item_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [2:0]         status;
    logic signed [15:0] sample_value;
    logic [15:0]        channel_index;
    logic [30:0]        frame_index;
    logic [15:0]        channel_count;
    logic [31:0]        sample_rate;
    logic [15:0]        bits_per_sample;
    logic [30:0]        frame_count;
    logic               last_result;
  } result_t;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_RIFF     = 3'd1;
  localparam logic [2:0] ST_NO_WAVE     = 3'd2;
  localparam logic [2:0] ST_NO_CHANNELS = 3'd3;
  localparam logic [2:0] ST_FEW_BITS    = 3'd4;
  localparam logic [2:0] ST_NO_DATA     = 3'd5;
  localparam logic [2:0] ST_NOT_16BIT   = 3'd6;
  localparam logic [2:0] ST_NO_FRAMES   = 3'd7;

  // Command passed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_ERROR  = 2'd0,
    OP_LENGTH = 2'd1,
    OP_DATA   = 2'd2
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  status;
    logic [31:0] value;
    logic        eof;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] bits;
  } cmd_t;

  typedef enum logic [1:0] {
    FRONT_HEAD   = 2'd0,
    FRONT_LENGTH = 2'd1,
    FRONT_DATA   = 2'd2,
    FRONT_DRAIN  = 2'd3
  } front_state_t;

  typedef enum logic [1:0] {
    BACK_IDLE   = 2'd0,
    BACK_DIVIDE = 2'd1,
    BACK_DATA   = 2'd2
  } back_state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [16:0] remainder;
  } div_rsp_t;

  // Both queue depths are powers of two so the pointers wrap by themselves.
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 4;

endpackage

// ===== rtl/wpsp_front.sv =====
module wpsp_front #(
  parameter int SEARCH_WINDOW = 8192
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  wpsp_pkg::item_t  item,
  output logic             cmd_push,
  output wpsp_pkg::cmd_t   cmd
);
  import wpsp_pkg::*;

  localparam int PW = $clog2(SEARCH_WINDOW);

  localparam logic [PW-1:0] POS_RIFF    = PW'(3);
  localparam logic [PW-1:0] POS_WAVE    = PW'(11);
  localparam logic [PW-1:0] POS_FMT     = PW'(15);
  localparam logic [PW-1:0] POS_CH_LO   = PW'(22);
  localparam logic [PW-1:0] POS_CH_HI   = PW'(23);
  localparam logic [PW-1:0] POS_RATE_LO = PW'(24);
  localparam logic [PW-1:0] POS_RATE_HI = PW'(27);
  localparam logic [PW-1:0] POS_BITS_LO = PW'(34);
  localparam logic [PW-1:0] POS_BITS_HI = PW'(35);
  localparam logic [PW-1:0] POS_SEARCH  = PW'(39);
  localparam logic [PW-1:0] POS_LAST    = PW'(SEARCH_WINDOW - 2);
  localparam logic [PW-1:0] CNT_RIFF    = PW'(4);
  localparam logic [PW-1:0] CNT_FMT     = PW'(16);
  localparam logic [PW-1:0] CNT_RATE    = PW'(24);
  localparam logic [PW-1:0] CNT_BITS    = PW'(36);

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666d_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [15:0] BITS_MIN = 16'd8;
  localparam logic [15:0] BITS_PCM = 16'd16;

  front_state_t  state, state_next;
  logic [PW-1:0] pos, pos_next;
  logic [31:0]   window, window_next;
  logic [15:0]   channels, channels_next;
  logic [31:0]   rate, rate_next;
  logic [15:0]   bits, bits_next;
  logic [31:0]   length, length_next;

  logic [31:0]   win;
  logic [PW-1:0] seen;
  logic          fail;
  logic [2:0]    fail_status;
  logic          to_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= FRONT_HEAD;
      pos      <= '0;
      window   <= '0;
      channels <= '0;
      rate     <= '0;
      bits     <= '0;
      length   <= '0;
    end else begin
      state    <= state_next;
      pos      <= pos_next;
      window   <= window_next;
      channels <= channels_next;
      rate     <= rate_next;
      bits     <= bits_next;
      length   <= length_next;
    end
  end

  always_comb begin
    state_next    = state;
    pos_next      = pos;
    window_next   = window;
    channels_next = channels;
    rate_next     = rate;
    bits_next     = bits;
    length_next   = length;
    cmd_push      = 1'b0;
    cmd           = '0;
    cmd.op        = OP_DATA;
    fail          = 1'b0;
    fail_status   = ST_OK;
    to_length     = 1'b0;
    win           = {window[23:0], item.file_byte};
    seen          = pos + 1'b1;

    if (accept) begin
      case (state)
        FRONT_HEAD: begin
          window_next = win;
          if (pos == POS_CH_LO) channels_next = {8'h00, item.file_byte};
          if (pos == POS_CH_HI) channels_next = {item.file_byte, channels[7:0]};
          if (pos >= POS_RATE_LO && pos <= POS_RATE_HI) begin
            rate_next = rate | (32'(item.file_byte) << {pos[1:0], 3'b000});
          end
          if (pos == POS_BITS_LO) bits_next = {8'h00, item.file_byte};
          if (pos == POS_BITS_HI) bits_next = {item.file_byte, bits[7:0]};

          if (pos == POS_RIFF && win != TAG_RIFF) begin
            fail = 1'b1; fail_status = ST_NO_RIFF;
          end else if (pos == POS_WAVE && win != TAG_WAVE) begin
            fail = 1'b1; fail_status = ST_NO_WAVE;
          end else if (pos == POS_FMT && win != TAG_FMT) begin
            fail = 1'b1; fail_status = ST_NO_WAVE;
          end else if (pos == POS_CH_HI && channels_next == 16'd0) begin
            fail = 1'b1; fail_status = ST_NO_CHANNELS;
          end else if (pos == POS_BITS_HI && bits_next < BITS_MIN) begin
            fail = 1'b1; fail_status = ST_FEW_BITS;
          end else if (pos >= POS_SEARCH && win == TAG_DATA) begin
            if (bits_next != BITS_PCM) begin
              fail = 1'b1; fail_status = ST_NOT_16BIT;
            end else begin
              to_length = 1'b1;
            end
          end else if (pos >= POS_LAST) begin
            fail = 1'b1; fail_status = ST_NO_DATA;
          end

          if (fail) begin
            cmd_push   = 1'b1;
            cmd.op     = OP_ERROR;
            cmd.status = fail_status;
            state_next = FRONT_DRAIN;
          end else if (to_length) begin
            state_next  = FRONT_LENGTH;
            pos_next    = '0;
            length_next = '0;
            // A tag on the last byte leaves an empty length behind it.
            if (item.end_of_file) begin
              cmd_push = 1'b1;
              cmd.op   = OP_LENGTH;
            end
          end else begin
            pos_next = seen;
            // A header cut short is judged as if zeros followed.
            if (item.end_of_file) begin
              cmd_push = 1'b1;
              cmd.op   = OP_ERROR;
              if (seen < CNT_RIFF) begin
                cmd.status = ST_NO_RIFF;
              end else if (seen < CNT_FMT) begin
                cmd.status = ST_NO_WAVE;
              end else if (seen < CNT_RATE) begin
                cmd.status = (channels_next == 16'd0) ? ST_NO_CHANNELS : ST_FEW_BITS;
              end else if (seen < CNT_BITS) begin
                cmd.status = (bits_next < BITS_MIN) ? ST_FEW_BITS : ST_NO_DATA;
              end else begin
                cmd.status = ST_NO_DATA;
              end
            end
          end
        end
        FRONT_LENGTH: begin
          length_next = length | (32'(item.file_byte) << {pos[1:0], 3'b000});
          pos_next    = pos + 1'b1;
          if (pos[1:0] == 2'd3 || item.end_of_file) begin
            cmd_push   = 1'b1;
            cmd.op     = OP_LENGTH;
            state_next = FRONT_DATA;
          end
        end
        FRONT_DATA: begin
          cmd_push = 1'b1;
          cmd.op   = OP_DATA;
        end
        FRONT_DRAIN: begin
        end
        default: begin
        end
      endcase

      cmd.eof      = item.end_of_file;
      cmd.channels = channels_next;
      cmd.rate     = rate_next;
      cmd.bits     = bits_next;
      if (cmd.op == OP_LENGTH) begin
        cmd.value = length_next;
      end else if (cmd.op == OP_DATA) begin
        cmd.value = {24'h00_0000, item.file_byte};
      end

      if (item.end_of_file) begin
        state_next    = FRONT_HEAD;
        pos_next      = '0;
        window_next   = '0;
        channels_next = '0;
        rate_next     = '0;
        bits_next     = '0;
        length_next   = '0;
      end
    end
  end

endmodule

// ===== rtl/wpsp_cmd_queue.sv =====
module wpsp_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wpsp_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output wpsp_pkg::cmd_t head
);
  import wpsp_pkg::*;

  localparam int AW = $clog2(CMD_DEPTH);

  cmd_t          mem [CMD_DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;

  assign full  = (count == (AW+1)'(CMD_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop && !empty) rp <= rp + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_cmd;
  end

endmodule

// ===== rtl/wpsp_div.sv =====
module wpsp_div (
  input  logic               clk,
  input  logic               rst,
  input  wpsp_pkg::div_req_t req,
  output wpsp_pkg::div_rsp_t rsp
);
  import wpsp_pkg::*;

  logic        busy;
  logic        done;
  logic [4:0]  step;
  logic [31:0] quo, quo_next;
  logic [16:0] rem, rem_next;
  logic [16:0] dvs;
  logic [17:0] shifted;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    shifted = {rem, quo[31]};
    if (shifted >= {1'b0, dvs}) begin
      rem_next = 17'(shifted - {1'b0, dvs});
      quo_next = {quo[30:0], 1'b1};
    end else begin
      rem_next = shifted[16:0];
      quo_next = {quo[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ===== rtl/wpsp_back.sv =====
module wpsp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_empty,
  input  wpsp_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  output logic              empty,
  input  logic              pop,
  output wpsp_pkg::result_t result
);
  import wpsp_pkg::*;

  localparam int RAW = $clog2(RES_DEPTH);

  back_state_t state, state_next;
  cmd_t        hold;
  logic [31:0] remaining, remaining_next;
  logic [30:0] frame, frame_next;
  logic [15:0] chan, chan_next;
  logic [7:0]  low, low_next;
  logic [16:0] chan_inc;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  result_t     res_mem [RES_DEPTH];
  logic [RAW-1:0] wp, rp;
  logic [RAW:0]   res_count;
  result_t     wr0, wr1, end_res;
  logic [1:0]  n_wr;
  logic        pop_ok;

  function automatic result_t make_result(kind_t k, logic [2:0] st, logic [15:0] sample,
                                          logic [15:0] ch, logic [30:0] fr, cmd_t src,
                                          logic [30:0] fcount, logic last);
    result_t r;
    r.kind            = k;
    r.status          = st;
    r.sample_value    = $signed(sample);
    r.channel_index   = ch;
    r.frame_index     = fr;
    r.channel_count   = src.channels;
    r.sample_rate     = src.rate;
    r.bits_per_sample = src.bits;
    r.frame_count     = fcount;
    r.last_result     = last;
    return r;
  endfunction

  wpsp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign pop_ok = pop && !empty;
  assign empty  = (res_count == '0);
  assign result = res_mem[rp];

  always_comb begin
    state_next       = state;
    remaining_next   = remaining;
    frame_next       = frame;
    chan_next        = chan;
    low_next         = low;
    wr0              = '0;
    wr1              = '0;
    end_res          = '0;
    n_wr             = 2'd0;
    div_req.start    = 1'b0;
    div_req.dividend = cmd.value;
    div_req.divisor  = {cmd.channels, 1'b0};
    chan_inc         = {1'b0, chan} + 17'd1;
    // Room for the two results that one command may cause.
    cmd_pop = !cmd_empty && state != BACK_DIVIDE &&
              res_count <= (RAW+1)'(RES_DEPTH - 2);

    if (div_rsp.done) begin
      if (div_rsp.quotient == 32'd0) begin
        wr0        = make_result(KIND_ERROR, ST_NO_FRAMES, '0, '0, '0, hold, '0, 1'b1);
        n_wr       = 2'd1;
        state_next = BACK_IDLE;
      end else begin
        wr0            = make_result(KIND_HEADER, ST_OK, '0, '0, '0, hold,
                                     div_rsp.quotient[30:0], 1'b0);
        n_wr           = 2'd1;
        // Whole frames only: the length less its remainder.
        remaining_next = hold.value - {15'h0000, div_rsp.remainder};
        frame_next     = '0;
        chan_next      = '0;
        state_next     = BACK_DATA;
        if (hold.eof) begin
          wr1        = make_result(KIND_END, ST_OK, '0, '0, '0, hold, '0, 1'b1);
          n_wr       = 2'd2;
          state_next = BACK_IDLE;
        end
      end
    end else if (cmd_pop) begin
      case (cmd.op)
        OP_ERROR: begin
          wr0        = make_result(KIND_ERROR, cmd.status, '0, '0, '0, cmd, '0, 1'b1);
          n_wr       = 2'd1;
          state_next = BACK_IDLE;
        end
        OP_LENGTH: begin
          div_req.start = 1'b1;
          state_next    = BACK_DIVIDE;
        end
        OP_DATA: begin
          if (state == BACK_DATA) begin
            remaining_next = remaining - 32'd1;
            if (!remaining[0]) begin
              low_next = cmd.value[7:0];
            end else begin
              wr0  = make_result(KIND_SAMPLE, ST_OK, {cmd.value[7:0], low}, chan, frame,
                                 cmd, '0, 1'b0);
              n_wr = 2'd1;
              if (chan_inc >= {1'b0, cmd.channels}) begin
                chan_next  = '0;
                frame_next = frame + 31'd1;
              end else begin
                chan_next = chan_inc[15:0];
              end
            end
            if (remaining_next == 32'd0 || cmd.eof) begin
              end_res    = make_result(KIND_END, ST_OK, '0, '0, '0, cmd, frame_next, 1'b1);
              state_next = BACK_IDLE;
              if (n_wr == 2'd0) begin
                wr0  = end_res;
                n_wr = 2'd1;
              end else begin
                wr1  = end_res;
                n_wr = 2'd2;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BACK_IDLE;
      wp        <= '0;
      rp        <= '0;
      res_count <= '0;
    end else begin
      state     <= state_next;
      wp        <= wp + RAW'(n_wr);
      if (pop_ok) rp <= rp + 1'b1;
      res_count <= res_count + (RAW+1)'(n_wr) - (RAW+1)'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    remaining <= remaining_next;
    frame     <= frame_next;
    chan      <= chan_next;
    low       <= low_next;
    if (div_req.start) hold <= cmd;
    if (n_wr != 2'd0) res_mem[wp] <= wr0;
    if (n_wr == 2'd2) res_mem[wp + 1'b1] <= wr1;
  end

`ifndef ASSERT_OFF
  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    res_count <= (RAW+1)'(RES_DEPTH))
    else $error("result queue count beyond its depth");

  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == BACK_DIVIDE)
    else $error("divider finished outside the divide state");

  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == BACK_DATA |-> remaining != 32'd0)
    else $error("data state with no bytes left");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    n_wr != 2'd0 |-> res_count <= (RAW+1)'(RES_DEPTH - 2) + (RAW+1)'(2'd2 - n_wr))
    else $error("result write without room");
`endif

endmodule

// ===== rtl/wav_pcm16_stream_parser.sv =====
// Channel   Direction  Handshake          Payload
// item      in         push / full        wpsp_pkg::item_t   (file_byte, end_of_file)
// result    out        empty / pop        wpsp_pkg::result_t (kind .. last_result)
//
// One file byte is taken per cycle while full is low; a sample result follows every
// second data byte. At most once per file the chunk length goes through a bit-serial
// divider, so the back end holds there while the two-entry command queue fills.
// Reset is synchronous on rst and clears all control state; payload holds no reset.
// full rises when the command queue is full; the back end stops taking commands while
// the four-entry result queue has fewer than two free slots.
module wav_pcm16_stream_parser #(
  parameter int SEARCH_WINDOW = 8192
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  wpsp_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output wpsp_pkg::result_t result
);
  import wpsp_pkg::*;

  logic accept;
  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_pop;
  logic cmd_empty;
  cmd_t cmd_head;

  assign accept = push && !full;

  wpsp_front #(
    .SEARCH_WINDOW (SEARCH_WINDOW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  wpsp_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .full     (full),
    .pop      (cmd_pop),
    .empty    (cmd_empty),
    .head     (cmd_head)
  );

  wpsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// ===== dv/wav_pcm16_stream_parser_tb.sv =====
module wav_pcm16_stream_parser_tb;
  import wpsp_pkg::*;

  localparam int SEARCH_WINDOW = 8192;
  localparam int RANDOM_BYTES = 700;
  localparam int DRAIN_CYCLES = 64;
  localparam longint TIMEOUT = 40_000_000;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666d7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;
  localparam logic [31:0] TAG_LIST = 32'h4c495354;

  typedef enum logic [1:0] {
    P_HEAD  = 2'd0,
    P_LEN   = 2'd1,
    P_DATA  = 2'd2,
    P_DRAIN = 2'd3
  } parse_phase_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    push = 1'b0;
  logic    pop = 1'b0;
  item_t   item = '0;
  logic    full;
  logic    empty;
  result_t result;

  logic [7:0] file_bytes[$];
  logic       tx_calm = 1'b0;
  logic       rx_calm = 1'b0;

  class wav_parse_scoreboard;
    result_t      pending_results[$];
    int           errors;
    parse_phase_t phase;
    logic [31:0]  byte_pos;
    logic [31:0]  tag_win;
    logic [31:0]  rate;
    logic [31:0]  remaining;
    logic [15:0]  channels;
    logic [15:0]  bits;
    logic [30:0]  frame_ctr;
    logic [15:0]  chan_ctr;
    logic [7:0]   low_hold;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase = P_HEAD;
      byte_pos = '0;
      tag_win = '0;
      rate = '0;
      remaining = '0;
      channels = '0;
      bits = '0;
      frame_ctr = '0;
      chan_ctr = '0;
      low_hold = '0;
    endfunction

    function void push_result(kind_t k, logic [2:0] st, logic [15:0] smp, logic [15:0] ch,
                              logic [30:0] fr, logic [30:0] fc, logic last);
      result_t r;
      r.kind = k;
      r.status = st;
      r.sample_value = smp;
      r.channel_index = ch;
      r.frame_index = fr;
      r.channel_count = channels;
      r.sample_rate = rate;
      r.bits_per_sample = bits;
      r.frame_count = fc;
      r.last_result = last;
      pending_results.push_back(r);
    endfunction

    function void reject(logic [2:0] st);
      push_result(KIND_ERROR, st, '0, '0, '0, '0, 1'b1);
      phase = P_DRAIN;
    endfunction

    // The chunk length is complete or was cut short: accept the header or
    // reject a file with no whole frame.
    function void close_length();
      logic [63:0] words;
      logic [63:0] frames;
      logic [63:0] span;
      words = {47'h0, channels, 1'b0};
      frames = (words != 0) ? {32'h0, remaining} / words : 64'h0;
      if (frames == 0) begin
        reject(ST_NO_FRAMES);
      end else begin
        push_result(KIND_HEADER, ST_OK, '0, '0, '0, frames[30:0], 1'b0);
        span = frames * words;
        remaining = span[31:0];
        frame_ctr = '0;
        chan_ctr = '0;
        phase = P_DATA;
      end
    endfunction

    function void take_byte(item_t it);
      logic [31:0] p;
      logic [7:0]  b;
      b = it.file_byte;
      case (phase)
        P_HEAD: begin
          p = byte_pos;
          tag_win = {tag_win[23:0], b};
          if (p == 3 && tag_win != TAG_RIFF) begin
            reject(ST_NO_RIFF);
          end else if ((p == 11 && tag_win != TAG_WAVE) || (p == 15 && tag_win != TAG_FMT)) begin
            reject(ST_NO_WAVE);
          end else begin
            if (p == 22) channels = {8'h00, b};
            if (p == 23) channels[15:8] = b;
            if (p >= 24 && p <= 27) rate = rate | ({24'h0, b} << (8 * (p - 24)));
            if (p == 34) bits = {8'h00, b};
            if (p == 35) bits[15:8] = b;
            if (p == 23 && channels == 0) begin
              reject(ST_NO_CHANNELS);
            end else if (p == 35 && bits < 8) begin
              reject(ST_FEW_BITS);
            end else if (p >= 39 && tag_win == TAG_DATA) begin
              if (bits != 16) begin
                reject(ST_NOT_16BIT);
              end else begin
                phase = P_LEN;
                byte_pos = '0;
                remaining = '0;
              end
            end else if (p >= SEARCH_WINDOW - 2) begin
              reject(ST_NO_DATA);
            end else begin
              byte_pos = p + 1;
            end
          end
        end
        P_LEN: begin
          remaining = remaining | ({24'h0, b} << (8 * byte_pos[1:0]));
          byte_pos = byte_pos + 1;
          if (byte_pos >= 4) close_length();
        end
        P_DATA: begin
          if (!remaining[0]) begin
            low_hold = b;
          end else begin
            push_result(KIND_SAMPLE, ST_OK, {b, low_hold}, chan_ctr, frame_ctr, '0, 1'b0);
            chan_ctr = chan_ctr + 16'd1;
            if (chan_ctr >= channels) begin
              chan_ctr = '0;
              frame_ctr = frame_ctr + 31'd1;
            end
          end
          remaining = remaining - 1;
          if (remaining == 0) begin
            push_result(KIND_END, ST_OK, '0, '0, '0, frame_ctr, 1'b1);
            phase = P_DRAIN;
          end
        end
        default: ;
      endcase

      if (it.end_of_file) begin
        // A header cut short is judged as if zero bytes followed.
        if (phase == P_HEAD) begin
          if (byte_pos < 4) reject(ST_NO_RIFF);
          else if (byte_pos < 16) reject(ST_NO_WAVE);
          else if (byte_pos < 24) reject((channels == 0) ? ST_NO_CHANNELS : ST_FEW_BITS);
          else if (byte_pos < 36) reject((bits < 8) ? ST_FEW_BITS : ST_NO_DATA);
          else reject(ST_NO_DATA);
        end
        if (phase == P_LEN) close_length();
        if (phase == P_DATA) push_result(KIND_END, ST_OK, '0, '0, '0, frame_ctr, 1'b1);
        clear_state();
      end
    endfunction

    function void compare_field(string name, logic signed [32:0] want, logic signed [32:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: kind %0d", got.kind);
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("kind", 33'(want.kind), 33'(got.kind));
        compare_field("status", 33'(want.status), 33'(got.status));
        compare_field("sample_value", 33'(want.sample_value), 33'(got.sample_value));
        compare_field("channel_index", 33'(want.channel_index), 33'(got.channel_index));
        compare_field("frame_index", 33'(want.frame_index), 33'(got.frame_index));
        compare_field("channel_count", 33'(want.channel_count), 33'(got.channel_count));
        compare_field("sample_rate", 33'(want.sample_rate), 33'(got.sample_rate));
        compare_field("bits_per_sample", 33'(want.bits_per_sample),
                      33'(got.bits_per_sample));
        compare_field("frame_count", 33'(want.frame_count), 33'(got.frame_count));
        compare_field("last_result", 33'(want.last_result), 33'(got.last_result));
      end
    endfunction
  endclass

  wav_parse_scoreboard parse_sb;

  always #4 clk = ~clk;

  wav_pcm16_stream_parser #(
    .SEARCH_WINDOW(SEARCH_WINDOW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result)
  );

  // Requests are noted before results so a same-edge result finds its prediction.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) parse_sb.take_byte(item);
      if (pop && !empty) parse_sb.check_result(result);
    end
  end

  function automatic void put8(input logic [7:0] v);
    file_bytes.push_back(v);
  endfunction

  function automatic void put16(input logic [15:0] v);
    put8(v[7:0]);
    put8(v[15:8]);
  endfunction

  function automatic void put32(input logic [31:0] v);
    put16(v[15:0]);
    put16(v[31:16]);
  endfunction

  function automatic void put_tag(input logic [31:0] t);
    put8(t[31:24]);
    put8(t[23:16]);
    put8(t[15:8]);
    put8(t[7:0]);
  endfunction

  // Canonical 36-byte RIFF and fmt header.
  function automatic void put_header(input logic [15:0] ch, input logic [31:0] sps,
                                     input logic [15:0] bps);
    file_bytes.delete();
    put_tag(TAG_RIFF);
    put32($urandom());
    put_tag(TAG_WAVE);
    put_tag(TAG_FMT);
    put32(32'd16);
    put16(16'd1);
    put16(ch);
    put32(sps);
    put32($urandom());
    put16(16'($urandom()));
    put16(bps);
  endfunction

  // Long padding is zero so that no stray tag shows up inside it.
  function automatic void put_body(input int extra_len, input logic [31:0] len, input int data_n);
    if (extra_len > 0) begin
      put_tag(TAG_LIST);
      put32(extra_len);
      for (int i = 0; i < extra_len; i++) begin
        put8(8'((extra_len < 64) ? $urandom_range(0, 255) : 0));
      end
    end
    put_tag(TAG_DATA);
    put32(len);
    for (int i = 0; i < data_n; i++) put8(8'($urandom_range(0, 255)));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= {b, eof};
    do @(posedge clk); while (full);
  endtask

  task automatic send_file(input int cut);
    for (int i = 0; i < cut; i++) send_byte(file_bytes[i], i == cut - 1);
  endtask

  task automatic run_directed();
    file_bytes.delete();
    put8(8'h52);
    send_file(1);

    put_header(16'd1, 32'd44100, 16'd16);
    file_bytes[3] = 8'h58;
    send_file(6);

    put_header(16'd2, 32'd48000, 16'd16);
    file_bytes[10] = 8'h00;
    send_file(12);

    put_header(16'd2, 32'd48000, 16'd16);
    file_bytes[15] = 8'h5f;
    send_file(20);

    put_header(16'd0, 32'd8000, 16'd16);
    send_file(24);

    put_header(16'd1, 32'd0, 16'd4);
    send_file(36);

    put_header(16'd2, 32'hFFFF_FFFF, 16'd24);
    put_body(0, 32'd8, 8);
    send_file(file_bytes.size());

    // Length too small for one frame.
    put_header(16'd1, 32'd22050, 16'd16);
    put_body(0, 32'd1, 1);
    send_file(file_bytes.size());

    // The end of the file lands on the byte that completes the data.
    put_header(16'd2, 32'd44100, 16'd16);
    put_body(0, 32'd8, 8);
    send_file(file_bytes.size());

    // Sample extremes followed by surplus bytes.
    put_header(16'd1, 32'd16000, 16'd16);
    put_body(0, 32'd6, 10);
    file_bytes[44] = 8'h00;
    file_bytes[45] = 8'h80;
    file_bytes[46] = 8'hff;
    file_bytes[47] = 8'h7f;
    file_bytes[48] = 8'h00;
    file_bytes[49] = 8'h00;
    send_file(file_bytes.size());

    // Short data ending inside a frame.
    put_header(16'd2, 32'd11025, 16'd16);
    put_body(0, 32'hFFFF_FFFF, 7);
    send_file(file_bytes.size());

    put_header(16'd1, 32'd32000, 16'd16);
    put_body(0, 32'd100, 0);
    send_file(42);
    send_file(40);

    put_header(16'd3, 32'd96000, 16'd16);
    put_body(0, 32'd600, 0);
    send_file(44);

    put_header(16'd0, 32'd8000, 16'd16);
    send_file(20);
    put_header(16'd5, 32'd8000, 16'd16);
    send_file(23);
    put_header(16'd1, 32'd8000, 16'd16);
    send_file(30);
    send_file(37);
    send_file(10);

    put_header(16'hFFFF, 32'd44100, 16'd16);
    put_body(0, 32'hFFFF_FFFF, 4);
    send_file(file_bytes.size());
  endtask

  task automatic run_random();
    int          sent;
    int          mode;
    int          frames;
    int          data_n;
    int          cut;
    logic [15:0] ch;
    logic [31:0] len;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      mode = $urandom_range(0, 9);
      tx_calm = ($urandom_range(0, 3) == 0);
      ch = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 3));
      put_header(ch, $urandom(), 16'((mode == 8) ? $urandom_range(0, 40) : 16));
      frames = $urandom_range(0, 6);
      if (ch > 3 || $urandom_range(0, 15) == 0) begin
        len = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom();
      end else begin
        len = frames * 2 * ch + $urandom_range(0, 3);
      end
      if (len > 64) data_n = $urandom_range(0, 12);
      else data_n = len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
      if ($urandom_range(0, 4) == 0) data_n = $urandom_range(0, data_n);
      put_body(($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0, len, data_n);
      cut = file_bytes.size();
      case (mode)
        6: file_bytes[$urandom_range(0, 43)] = 8'($urandom_range(0, 255));
        7: cut = $urandom_range(1, file_bytes.size());
        9: begin
          file_bytes.delete();
          if ($urandom_range(0, 1) == 1) put_tag(TAG_RIFF);
          repeat ($urandom_range(1, 20)) put8(8'($urandom_range(0, 255)));
          cut = file_bytes.size();
        end
        default: ;
      endcase
      send_file(cut);
      sent += cut;
    end
  endtask

  initial begin : result_sink
    int gap;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
      gap = rx_calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  initial begin : stimulus
    parse_sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    push <= 1'b0;
    do @(posedge clk); while (parse_sb.pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (parse_sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("simulation failed");
    $finish;
  end

endmodule
